// ----- hdl/nps3_pkg.sv -----
// Package for the 3D nearest point search unit.
// Holds coordinate and distance widths and the request, response and queue entry types.
// No dependencies.
package nps3_pkg;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 16;
    localparam int DIST_W  = 36;
    // magnitude of a coordinate difference and its square
    localparam int MAG_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * MAG_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [INDEX_W-1:0]        t_index;
    typedef logic [DIST_W-1:0]         t_dist;

    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
        t_coord query_z;
        t_coord cand_x;
        t_coord cand_y;
        t_coord cand_z;
        t_index cand_index;
        t_dist  start_best;
        logic   first_of_query;
        logic   last_of_query;
    } t_req;

    typedef struct packed {
        t_dist  best_dist_sqr;
        t_index best_index;
        t_coord best_x;
        t_coord best_y;
        t_coord best_z;
        logic   found;
    } t_rsp;

    // one classified candidate, carried from front to back
    typedef struct packed {
        t_dist  dist_sqr;
        t_index cand_index;
        t_coord cand_x;
        t_coord cand_y;
        t_coord cand_z;
        t_dist  start_best;
        logic   first;
        logic   last;
    } t_item;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_queue_status;

endpackage

// ----- hdl/nps3_front.sv -----
// Front end of the nearest point search: accepts requests and computes the
// exact squared distance in two stages. Depends on nps3_pkg.
module nps3_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    output logic                    o_req_stall,
    input  nps3_pkg::t_req          i_req,
    output logic                    o_push,
    output nps3_pkg::t_item         o_item,
    input  nps3_pkg::t_queue_status i_q_status
);

    typedef struct packed {
        logic [nps3_pkg::MAG_W-1:0] mag_x;
        logic [nps3_pkg::MAG_W-1:0] mag_y;
        logic [nps3_pkg::MAG_W-1:0] mag_z;
        nps3_pkg::t_index           cand_index;
        nps3_pkg::t_coord           cand_x;
        nps3_pkg::t_coord           cand_y;
        nps3_pkg::t_coord           cand_z;
        nps3_pkg::t_dist            start_best;
        logic                       first;
        logic                       last;
    } t_s1;

    function automatic logic [nps3_pkg::MAG_W-1:0] abs_diff(
        input nps3_pkg::t_coord a,
        input nps3_pkg::t_coord b
    );
        logic signed [nps3_pkg::MAG_W-1:0] d;
        d = nps3_pkg::MAG_W'(a) - nps3_pkg::MAG_W'(b);
        abs_diff = d[nps3_pkg::MAG_W-1] ? nps3_pkg::MAG_W'(-d) : nps3_pkg::MAG_W'(d);
    endfunction

    logic                      r_s1_valid;
    t_s1                       r_s1;
    logic                      r_s2_valid;
    nps3_pkg::t_item           r_s2;
    logic                      s1_free;
    logic                      s2_load;
    logic                      push;
    logic [nps3_pkg::SQ_W-1:0] sq_x;
    logic [nps3_pkg::SQ_W-1:0] sq_y;
    logic [nps3_pkg::SQ_W-1:0] sq_z;
    nps3_pkg::t_dist           sum_sq;

    // advance stages whenever the next one frees up
    always_comb begin
        push    = r_s2_valid && !i_q_status.full;
        s2_load = r_s1_valid && (!r_s2_valid || push);
        s1_free = !r_s1_valid || s2_load;
    end

    assign o_req_stall = !s1_free;
    assign o_push      = push;
    assign o_item      = r_s2;

    // square the magnitudes and sum them; the sum never exceeds the distance width
    always_comb begin
        sq_x   = nps3_pkg::SQ_W'(r_s1.mag_x) * nps3_pkg::SQ_W'(r_s1.mag_x);
        sq_y   = nps3_pkg::SQ_W'(r_s1.mag_y) * nps3_pkg::SQ_W'(r_s1.mag_y);
        sq_z   = nps3_pkg::SQ_W'(r_s1.mag_z) * nps3_pkg::SQ_W'(r_s1.mag_z);
        sum_sq = nps3_pkg::DIST_W'(sq_x) + nps3_pkg::DIST_W'(sq_y) + nps3_pkg::DIST_W'(sq_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_req_valid;
            end
            if (s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (push) begin
                r_s2_valid <= 1'b0;
            end
        end
        // stage 1: coordinate differences
        if (s1_free) begin
            r_s1.mag_x      <= abs_diff(i_req.cand_x, i_req.query_x);
            r_s1.mag_y      <= abs_diff(i_req.cand_y, i_req.query_y);
            r_s1.mag_z      <= abs_diff(i_req.cand_z, i_req.query_z);
            r_s1.cand_index <= i_req.cand_index;
            r_s1.cand_x     <= i_req.cand_x;
            r_s1.cand_y     <= i_req.cand_y;
            r_s1.cand_z     <= i_req.cand_z;
            r_s1.start_best <= i_req.start_best;
            r_s1.first      <= i_req.first_of_query;
            r_s1.last       <= i_req.last_of_query;
        end
        // stage 2: squared distance
        if (s2_load) begin
            r_s2.dist_sqr   <= sum_sq;
            r_s2.cand_index <= r_s1.cand_index;
            r_s2.cand_x     <= r_s1.cand_x;
            r_s2.cand_y     <= r_s1.cand_y;
            r_s2.cand_z     <= r_s1.cand_z;
            r_s2.start_best <= r_s1.start_best;
            r_s2.first      <= r_s1.first;
            r_s2.last       <= r_s1.last;
        end
    end

endmodule

// ----- hdl/nps3_queue.sv -----
// Short queue between the front and back of the nearest point search.
// Register array with head and tail pointers. Depends on nps3_pkg.
module nps3_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  nps3_pkg::t_item         i_item,
    input  logic                    i_pop,
    output nps3_pkg::t_item         o_item,
    output nps3_pkg::t_queue_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    nps3_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == FULL_CNT);
    assign o_item             = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.not_empty;

    // advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hdl/nps3_back.sv -----
// Back end of the nearest point search: keeps the running best candidate
// and registers a response on the last request of a query. Depends on nps3_pkg.
module nps3_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  nps3_pkg::t_item         i_item,
    input  nps3_pkg::t_queue_status i_q_status,
    output logic                    o_pop,
    output logic                    o_rsp_valid,
    input  logic                    i_rsp_stall,
    output nps3_pkg::t_rsp          o_rsp
);

    nps3_pkg::t_dist  r_best_dist;
    nps3_pkg::t_index r_best_index;
    nps3_pkg::t_coord r_best_x;
    nps3_pkg::t_coord r_best_y;
    nps3_pkg::t_coord r_best_z;
    logic             r_found;
    logic             r_rsp_valid;
    nps3_pkg::t_rsp   r_rsp;

    nps3_pkg::t_dist  n_best_dist;
    nps3_pkg::t_index n_best_index;
    nps3_pkg::t_coord n_best_x;
    nps3_pkg::t_coord n_best_y;
    nps3_pkg::t_coord n_best_z;
    logic             n_found;
    logic             out_free;
    logic             pop;

    // take an entry unless it ends a query and the response slot is busy
    always_comb begin
        out_free = !r_rsp_valid || !i_rsp_stall;
        pop      = i_q_status.not_empty && (!i_item.last || out_free);
    end

    assign o_pop       = pop;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // restart on a first mark, then keep a strictly smaller distance
    always_comb begin
        if (i_item.first) begin
            n_best_dist  = i_item.start_best;
            n_best_index = '0;
            n_best_x     = '0;
            n_best_y     = '0;
            n_best_z     = '0;
            n_found      = 1'b0;
        end else begin
            n_best_dist  = r_best_dist;
            n_best_index = r_best_index;
            n_best_x     = r_best_x;
            n_best_y     = r_best_y;
            n_best_z     = r_best_z;
            n_found      = r_found;
        end
        if (i_item.dist_sqr < n_best_dist) begin
            n_best_dist  = i_item.dist_sqr;
            n_best_index = i_item.cand_index;
            n_best_x     = i_item.cand_x;
            n_best_y     = i_item.cand_y;
            n_best_z     = i_item.cand_z;
            n_found      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist  <= '0;
            r_best_index <= '0;
            r_best_x     <= '0;
            r_best_y     <= '0;
            r_best_z     <= '0;
            r_found      <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_best_dist  <= n_best_dist;
                r_best_index <= n_best_index;
                r_best_x     <= n_best_x;
                r_best_y     <= n_best_y;
                r_best_z     <= n_best_z;
                r_found      <= n_found;
            end
            // hold the response until taken
            if (pop && i_item.last) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
        if (pop && i_item.last) begin
            r_rsp.best_dist_sqr <= n_best_dist;
            r_rsp.best_index    <= n_found ? n_best_index : '0;
            r_rsp.best_x        <= n_found ? n_best_x : '0;
            r_rsp.best_y        <= n_found ? n_best_y : '0;
            r_rsp.best_z        <= n_found ? n_best_z : '0;
            r_rsp.found         <= n_found;
        end
    end

endmodule

// ----- hdl/nearest_point_search_3d_unit.sv -----
// Nearest point search, 3D squared Euclidean distance, top level.
// Path: stage 1 and stage 2 registers, queue entry, then the response register.
// Throughput: one request per cycle when not stalled, set by the two-stage
// distance pipe and single compare-and-update of the back end's running best.
// Reset: synchronous active-low; empties pipe and queue, zeroes running best.
// Uses nps3_pkg, nps3_front, nps3_queue, nps3_back.
module nearest_point_search_3d_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  nps3_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output nps3_pkg::t_rsp o_rsp
);

    logic                    push;
    logic                    pop;
    nps3_pkg::t_item         front_item;
    nps3_pkg::t_item         back_item;
    nps3_pkg::t_queue_status q_status;

    nps3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_push      (push),
        .o_item      (front_item),
        .i_q_status  (q_status)
    );

    nps3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (back_item),
        .o_status (q_status)
    );

    nps3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (back_item),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- hdl/nps3_checker.sv -----
// Port-level checks for the nearest point search unit, bound to its top level.
// Depends on nps3_pkg and nearest_point_search_3d_unit.
module nps3_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_rsp_valid,
    input logic           i_rsp_stall,
    input nps3_pkg::t_rsp o_rsp
);

    // largest exact distance: three full-range squared differences
    localparam nps3_pkg::t_dist MAX_DIST = nps3_pkg::DIST_W'(3) *
        nps3_pkg::DIST_W'(65535) * nps3_pkg::DIST_W'(65535);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // no response is left over from before reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    // a miss reports a cleared point and index
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.found |-> o_rsp.best_index == '0 &&
            o_rsp.best_x == '0 && o_rsp.best_y == '0 && o_rsp.best_z == '0)
        else $error("miss reports nonzero point");

    // a hit reports a reachable distance
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.found |-> o_rsp.best_dist_sqr <= MAX_DIST)
        else $error("hit distance out of range");

endmodule

bind nearest_point_search_3d_unit nps3_checker u_nps3_checker (.*);

// ----- tb/nearest_point_search_3d_unit_tb.sv -----
// Testbench for the 3D nearest point search unit: directed corner rows, then random queries.
// Checks each response against a running nearest-candidate tracker kept in the bench.
// Depends on nps3_pkg and nearest_point_search_3d_unit.
module nearest_point_search_3d_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RANDOM_ITEMS = 1550;
    localparam int     RESET_CYCLES = 12;
    localparam int     TAIL_CYCLES  = 16;
    localparam int     MAX_REPORTS  = 10;
    localparam longint DIST_MAX     = (longint'(1) << nps3_pkg::DIST_W) - 1;
    localparam longint DIFF_LIMIT   = longint'(1) << 18;

    typedef struct {
        nps3_pkg::t_req req;
        bit             typed;
        nps3_pkg::t_rsp rsp;
    } t_stim_row;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_req_valid = 1'b0;
    logic           i_rsp_stall = 1'b0;
    nps3_pkg::t_req i_req       = '0;
    logic           o_req_stall;
    logic           o_rsp_valid;
    nps3_pkg::t_rsp o_rsp;

    // running nearest candidate as the bench sees it
    nps3_pkg::t_dist  run_dist  = '0;
    nps3_pkg::t_index run_index = '0;
    nps3_pkg::t_coord run_x     = '0;
    nps3_pkg::t_coord run_y     = '0;
    nps3_pkg::t_coord run_z     = '0;
    logic             run_found = 1'b0;

    nps3_pkg::t_rsp nearest_exp_q[$];
    t_stim_row      stim_rows[$];

    int  mismatch_count = 0;
    int  rsp_checked    = 0;
    int  rsp_found      = 0;
    int  req_sent       = 0;
    int  query_count    = 0;
    bit  drain_first    = 1'b0;
    bit  rsp_calm       = 1'b0;
    int  stall_run      = 0;
    int  stall_pick     = 0;

    nearest_point_search_3d_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic nps3_pkg::t_req mk_req(input int qx, input int qy, input int qz,
                                              input int cx, input int cy, input int cz,
                                              input int idx, input nps3_pkg::t_dist start,
                                              input bit first, input bit last);
        nps3_pkg::t_req r;
        r.query_x        = nps3_pkg::t_coord'(qx);
        r.query_y        = nps3_pkg::t_coord'(qy);
        r.query_z        = nps3_pkg::t_coord'(qz);
        r.cand_x         = nps3_pkg::t_coord'(cx);
        r.cand_y         = nps3_pkg::t_coord'(cy);
        r.cand_z         = nps3_pkg::t_coord'(cz);
        r.cand_index     = nps3_pkg::t_index'(idx);
        r.start_best     = start;
        r.first_of_query = first;
        r.last_of_query  = last;
        return r;
    endfunction

    function automatic nps3_pkg::t_rsp mk_rsp(input nps3_pkg::t_dist best, input int idx,
                                              input int x, input int y, input int z,
                                              input bit found);
        nps3_pkg::t_rsp r;
        r.best_dist_sqr = best;
        r.best_index    = nps3_pkg::t_index'(idx);
        r.best_x        = nps3_pkg::t_coord'(x);
        r.best_y        = nps3_pkg::t_coord'(y);
        r.best_z        = nps3_pkg::t_coord'(z);
        r.found         = found;
        return r;
    endfunction

    // square of one coordinate difference, clamped as for wide coordinates
    function automatic longint sq_diff(input nps3_pkg::t_coord a, input nps3_pkg::t_coord b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        if (d > DIFF_LIMIT) d = DIFF_LIMIT;
        return d * d;
    endfunction

    // advance the running best by one request; report the response it causes
    task automatic track_nearest(input nps3_pkg::t_req r, output bit emit,
                                 output nps3_pkg::t_rsp rsp);
        longint cand_dist;
        if (r.first_of_query) begin
            run_dist  = r.start_best;
            run_index = '0;
            run_x     = '0;
            run_y     = '0;
            run_z     = '0;
            run_found = 1'b0;
        end
        cand_dist = sq_diff(r.cand_x, r.query_x) + sq_diff(r.cand_y, r.query_y)
                  + sq_diff(r.cand_z, r.query_z);
        if (cand_dist > DIST_MAX) cand_dist = DIST_MAX;
        // strict compare: a tie keeps the earlier candidate
        if (nps3_pkg::t_dist'(cand_dist) < run_dist) begin
            run_dist  = nps3_pkg::t_dist'(cand_dist);
            run_index = r.cand_index;
            run_x     = r.cand_x;
            run_y     = r.cand_y;
            run_z     = r.cand_z;
            run_found = 1'b1;
        end
        emit = r.last_of_query;
        rsp  = '0;
        rsp.best_dist_sqr = run_dist;
        if (run_found) begin
            rsp.best_index = run_index;
            rsp.best_x     = run_x;
            rsp.best_y     = run_y;
            rsp.best_z     = run_z;
            rsp.found      = 1'b1;
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic nps3_pkg::t_dist rand_dist();
        return nps3_pkg::t_dist'({$urandom, $urandom});
    endfunction

    // present one request, hold it through stalls, record what it should produce
    task automatic send_request(input nps3_pkg::t_req r, input int gap, input bit typed,
                                input nps3_pkg::t_rsp typed_rsp);
        bit             emit;
        nps3_pkg::t_rsp want;
        if (gap > 0 || drain_first) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
            while (drain_first && nearest_exp_q.size() != 0) @(posedge i_clk);
            repeat (gap) @(posedge i_clk);
            drain_first = 1'b0;
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        track_nearest(r, emit, want);
        if (emit) nearest_exp_q.push_back(typed ? typed_rsp : want);
        req_sent++;
    endtask

    // randomize response stall: short and long stalls, with stall-free stretches
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (rsp_calm) begin
            i_rsp_stall <= 1'b0;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60) begin
                i_rsp_stall <= 1'b0;
                stall_run   <= $urandom_range(0, 20);
            end else if (stall_pick < 92) begin
                i_rsp_stall <= 1'b1;
                stall_run   <= $urandom_range(0, 2);
            end else begin
                i_rsp_stall <= 1'b1;
                stall_run   <= $urandom_range(10, 40);
            end
        end
    end

    // check each accepted response against the oldest expectation
    always @(posedge i_clk) begin
        nps3_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (nearest_exp_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected response: dist=%h idx=%h pt=(%h,%h,%h) found=%b",
                             o_rsp.best_dist_sqr, o_rsp.best_index, o_rsp.best_x,
                             o_rsp.best_y, o_rsp.best_z, o_rsp.found);
            end else begin
                want = nearest_exp_q.pop_front();
                rsp_checked++;
                if (want.found) rsp_found++;
                if (o_rsp.best_dist_sqr !== want.best_dist_sqr ||
                    o_rsp.best_index !== want.best_index ||
                    o_rsp.best_x !== want.best_x || o_rsp.best_y !== want.best_y ||
                    o_rsp.best_z !== want.best_z || o_rsp.found !== want.found) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: exp dist=%h idx=%h pt=(%h,%h,%h) found=%b",
                                 want.best_dist_sqr, want.best_index, want.best_x,
                                 want.best_y, want.best_z, want.found);
                        $display("          got dist=%h idx=%h pt=(%h,%h,%h) found=%b",
                                 o_rsp.best_dist_sqr, o_rsp.best_index, o_rsp.best_x,
                                 o_rsp.best_y, o_rsp.best_z, o_rsp.found);
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        nps3_pkg::t_req  r;
        int              pick;
        int              qlen;
        int              rad;
        int              qx, qy, qz;
        int              off[3];
        int              prev_off[3];
        nps3_pkg::t_dist start;
        bit              broken;
        bit              drop_first;
        bit              far_cand;
        bit              drained_mid;
        bit              first_mark;
        bit              last_mark;

        drained_mid = 1'b0;
        prev_off    = '{0, 0, 0};

        // after reset with no first mark: best distance is zero, nothing beats it
        stim_rows.push_back('{mk_req(0, 0, 0, 0, 0, 0, 3, 36'd500, 1'b0, 1'b1), 1'b1,
                              mk_rsp(36'd0, 0, 0, 0, 0, 1'b0)});
        // coordinate extremes, widest distance
        stim_rows.push_back('{mk_req(-32768, -32768, -32768, 32767, 32767, 32767, 16'hFFFF,
                                     nps3_pkg::t_dist'(DIST_MAX), 1'b1, 1'b1), 1'b1,
                              mk_rsp(36'd12884508675, 16'hFFFF, 32767, 32767, 32767, 1'b1)});
        stim_rows.push_back('{mk_req(32767, 32767, 32767, -32768, -32768, -32768, 0,
                                     nps3_pkg::t_dist'(DIST_MAX), 1'b1, 1'b1), 1'b1,
                              mk_rsp(36'd12884508675, 0, -32768, -32768, -32768, 1'b1)});
        // starting distance zero: nothing found
        stim_rows.push_back('{mk_req(1234, -77, 9, -500, 600, -700, 16'h1111, 36'd0,
                                     1'b1, 1'b1), 1'b1, mk_rsp(36'd0, 0, 0, 0, 0, 1'b0)});
        // exact hit beats a starting distance of one
        stim_rows.push_back('{mk_req(100, -200, 300, 100, -200, 300, 7, 36'd1, 1'b1, 1'b1),
                              1'b1, mk_rsp(36'd0, 7, 100, -200, 300, 1'b1)});
        // equal to the starting distance: not strictly smaller
        stim_rows.push_back('{mk_req(0, 0, 0, 256, 0, 0, 9, 36'd65536, 1'b1, 1'b1), 1'b1,
                              mk_rsp(36'd65536, 0, 0, 0, 0, 1'b0)});
        // ties keep the earliest candidate
        stim_rows.push_back('{mk_req(0, 0, 0, 1, 0, 0, 5, nps3_pkg::t_dist'(DIST_MAX),
                                     1'b1, 1'b0), 1'b0, nps3_pkg::t_rsp'(0)});
        stim_rows.push_back('{mk_req(0, 0, 0, 0, -1, 0, 6, 36'd0, 1'b0, 1'b0), 1'b0,
                              nps3_pkg::t_rsp'(0)});
        stim_rows.push_back('{mk_req(0, 0, 0, 0, 0, -1, 7, 36'd0, 1'b0, 1'b1), 1'b0,
                              nps3_pkg::t_rsp'(0)});
        // improvement in the middle of a longer query
        stim_rows.push_back('{mk_req(-256, 512, 128, 1000, 1000, 1000, 10,
                                     nps3_pkg::t_dist'(DIST_MAX), 1'b1, 1'b0), 1'b0,
                              nps3_pkg::t_rsp'(0)});
        stim_rows.push_back('{mk_req(-256, 512, 128, -246, 492, 158, 11, 36'd0, 1'b0, 1'b0),
                              1'b0, nps3_pkg::t_rsp'(0)});
        stim_rows.push_back('{mk_req(-256, 512, 128, 4744, 512, 128, 12, 36'd0, 1'b0, 1'b0),
                              1'b0, nps3_pkg::t_rsp'(0)});
        stim_rows.push_back('{mk_req(-256, 512, 128, -259, 516, 128, 13, 36'd0, 1'b0, 1'b1),
                              1'b0, nps3_pkg::t_rsp'(0)});
        // missing first mark: continue the state left by the previous query
        stim_rows.push_back('{mk_req(-256, 512, 128, -256, 512, 128, 14, 36'd0, 1'b0, 1'b0),
                              1'b0, nps3_pkg::t_rsp'(0)});
        stim_rows.push_back('{mk_req(-256, 512, 128, 0, 0, 0, 15, 36'd0, 1'b0, 1'b1),
                              1'b0, nps3_pkg::t_rsp'(0)});
        // far candidate on the last item does not displace the best
        stim_rows.push_back('{mk_req(50, 50, 50, 52, 50, 50, 16, 36'd1000000, 1'b1, 1'b0),
                              1'b0, nps3_pkg::t_rsp'(0)});
        stim_rows.push_back('{mk_req(50, 50, 50, -30000, 0, 0, 17, 36'd0, 1'b0, 1'b1),
                              1'b0, nps3_pkg::t_rsp'(0)});

        // hold reset, then release
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        foreach (stim_rows[i])
            send_request(stim_rows[i].req, pick_gap(), stim_rows[i].typed, stim_rows[i].rsp);
        drain_first = 1'b1;

        // random queries: mostly well-formed, some broken, some pure noise
        while (req_sent < stim_rows.size() + RANDOM_ITEMS) begin
            query_count++;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                r = mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, rand_dist(), $urandom_range(0, 1),
                           $urandom_range(0, 1));
                rsp_calm = ((req_sent % 400) < 60);
                send_request(r, rsp_calm ? 0 : pick_gap(), 1'b0, nps3_pkg::t_rsp'(0));
            end else begin
                qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(1, 8);
                pick = $urandom_range(0, 99);
                if (pick < 70)      start = nps3_pkg::t_dist'(DIST_MAX);
                else if (pick < 85) start = rand_dist();
                else if (pick < 95) start = nps3_pkg::t_dist'($urandom_range(0, 1 << 20));
                else                start = '0;
                if ($urandom_range(0, 1)) begin
                    qx = int'(nps3_pkg::t_coord'($urandom));
                    qy = int'(nps3_pkg::t_coord'($urandom));
                    qz = int'(nps3_pkg::t_coord'($urandom));
                end else begin
                    qx = int'($urandom_range(0, 2047)) - 1024;
                    qy = int'($urandom_range(0, 2047)) - 1024;
                    qz = int'($urandom_range(0, 2047)) - 1024;
                end
                pick = $urandom_range(0, 3);
                rad  = (pick == 0) ? 4 : (pick == 1) ? 64 : (pick == 2) ? 2048 : 32767;
                broken     = ($urandom_range(0, 19) == 0);
                drop_first = $urandom_range(0, 1);
                for (int k = 0; k < qlen; k++) begin
                    far_cand = ($urandom_range(0, 9) < 3);
                    if (k > 0 && $urandom_range(0, 99) < 15) begin
                        // mirrored offset gives the same distance
                        off[0] = -prev_off[0];
                        off[1] = -prev_off[1];
                        off[2] = prev_off[2];
                    end else begin
                        foreach (off[j]) off[j] = int'($urandom_range(0, 2 * rad)) - rad;
                    end
                    prev_off   = off;
                    first_mark = (k == 0) && !(broken && drop_first);
                    last_mark  = (k == qlen - 1) && !(broken && !drop_first);
                    if (far_cand)
                        r = mk_req(qx, qy, qz, $urandom, $urandom, $urandom, $urandom,
                                   start, first_mark, last_mark);
                    else
                        r = mk_req(qx, qy, qz, qx + off[0], qy + off[1], qz + off[2],
                                   $urandom, start, first_mark, last_mark);
                    rsp_calm = ((req_sent % 400) < 60);
                    send_request(r, rsp_calm ? 0 : pick_gap(), 1'b0, nps3_pkg::t_rsp'(0));
                end
            end
            // pause once midway until every response has come back
            if (!drained_mid && req_sent >= stim_rows.size() + RANDOM_ITEMS / 2) begin
                drained_mid = 1'b1;
                drain_first = 1'b1;
            end
        end

        // drop valid and let the pipe empty
        i_req_valid <= 1'b0;
        rsp_calm = 1'b0;
        while (nearest_exp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests in %0d directed rows and %0d random queries.",
                 req_sent, stim_rows.size(), query_count);
        $display("Checked %0d responses, %0d of them with a nearer point found.",
                 rsp_checked, rsp_found);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/nps3_pkg.sv
hdl/nps3_front.sv
hdl/nps3_queue.sv
hdl/nps3_back.sv
hdl/nearest_point_search_3d_unit.sv
hdl/nps3_checker.sv
tb/nearest_point_search_3d_unit_tb.sv
